// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RDSF_ASSERT(label, clk_i, rstn_i, expr) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (expr)) \
        else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define RDSF_ASSERT_NEXT(label, clk_i, rstn_i, pre, post) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/rdsf_pkg.sv =====
package rdsf_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int WCNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int UPC_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [UPC_W-1:0]  upc_t;
    typedef logic [WCNT_W-1:0] wcnt_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CONN   = 3'd1,
        PH_SEND   = 3'd2,
        PH_DISC   = 3'd3,
        PH_CLOSED = 3'd4,
        PH_FAILED = 3'd5
    } phase_t;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_ACK     = 3'd1;
    localparam logic [2:0] REQ_RST     = 3'd2;
    localparam logic [2:0] REQ_OTHER   = 3'd3;
    localparam logic [2:0] REQ_TIMEOUT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = 3'd4;

    localparam logic [3:0] FLAG_NONE = 4'b0000;
    localparam logic [3:0] FLAG_SYN  = 4'b0001;
    localparam logic [3:0] FLAG_FIN  = 4'b0010;
    localparam logic [3:0] FLAG_DAT  = 4'b0100;
    localparam logic [3:0] FLAG_RES  = 4'b1000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_START,
        OP_EMIT,
        OP_CLR_TMO,
        OP_CHK_ACK1,
        OP_INC_SEQ,
        OP_PHASE,
        OP_ACK_SEQ,
        OP_REWIND,
        OP_BUMP_RST,
        OP_BUMP_TMO,
        OP_IDX,
        OP_CHK_IDX,
        OP_WIN_INIT,
        OP_DAT,
        OP_FLUSH
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_FLAG,
        C_NFLAG,
        C_MORE,
        C_WAIT
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        upc_t       target;
        logic [3:0] flags;
        phase_t     phase;
    } ctrl_word_t;

    typedef struct packed {
        logic flag;
        logic more;
        logic stall;
    } status_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  flags;
        logic [31:0] seq;
        logic [11:0] len;
        logic [30:0] off;
        phase_t      phase;
        logic        last;
    } result_t;

    // Microprogram entry points and steps
    localparam upc_t A_DISPATCH  = upc_t'(0);
    localparam upc_t A_START     = upc_t'(1);
    localparam upc_t A_CONN_ACK  = upc_t'(3);
    localparam upc_t A_SYNRES    = upc_t'(8);
    localparam upc_t A_CONN_RST  = upc_t'(9);
    localparam upc_t A_FAIL      = upc_t'(13);
    localparam upc_t A_CONN_TMO  = upc_t'(14);
    localparam upc_t A_SEND_ACK  = upc_t'(17);
    localparam upc_t A_SEND_RST  = upc_t'(24);
    localparam upc_t A_SEND_TMO  = upc_t'(29);
    localparam upc_t A_DISC_ACK  = upc_t'(32);
    localparam upc_t A_FINRES    = upc_t'(35);
    localparam upc_t A_DISC_RST  = upc_t'(36);
    localparam upc_t A_DISC_TMO  = upc_t'(40);
    localparam upc_t A_BAD_PHASE = upc_t'(43);
    localparam upc_t A_WINDOW    = upc_t'(44);
    localparam upc_t A_WIN_LOOP  = upc_t'(45);
    localparam upc_t A_FINISH    = upc_t'(49);

    function automatic ctrl_word_t cw(op_t op, cond_t cond, upc_t target,
                                      logic [3:0] flags, phase_t phase);
        ctrl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.flags  = flags;
        w.phase  = phase;
        return w;
    endfunction

    function automatic ctrl_word_t ucode_rom(upc_t upc);
        ctrl_word_t w;
        case (upc)
            6'd0:  w = cw(OP_NOP,      C_WAIT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            // start
            6'd1:  w = cw(OP_START,    C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd2:  w = cw(OP_EMIT,     C_ALWAYS, A_FINISH,   FLAG_SYN,  PH_IDLE);
            // ack while connecting
            6'd3:  w = cw(OP_CLR_TMO,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd4:  w = cw(OP_CHK_ACK1, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd5:  w = cw(OP_NOP,      C_NFLAG,  A_SYNRES,   FLAG_NONE, PH_IDLE);
            6'd6:  w = cw(OP_INC_SEQ,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd7:  w = cw(OP_PHASE,    C_ALWAYS, A_WINDOW,   FLAG_NONE, PH_SEND);
            6'd8:  w = cw(OP_EMIT,     C_ALWAYS, A_FINISH,   FLAG_SYN | FLAG_RES, PH_IDLE);
            // reset while connecting
            6'd9:  w = cw(OP_CLR_TMO,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd10: w = cw(OP_BUMP_RST, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd11: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd12: w = cw(OP_NOP,      C_ALWAYS, A_SYNRES,   FLAG_NONE, PH_IDLE);
            6'd13: w = cw(OP_PHASE,    C_ALWAYS, A_FINISH,   FLAG_NONE, PH_FAILED);
            // timeout while connecting
            6'd14: w = cw(OP_BUMP_TMO, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd15: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd16: w = cw(OP_NOP,      C_ALWAYS, A_SYNRES,   FLAG_NONE, PH_IDLE);
            // ack while sending
            6'd17: w = cw(OP_CLR_TMO,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd18: w = cw(OP_ACK_SEQ,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd19: w = cw(OP_IDX,      C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd20: w = cw(OP_CHK_IDX,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd21: w = cw(OP_NOP,      C_NFLAG,  A_WINDOW,   FLAG_NONE, PH_IDLE);
            6'd22: w = cw(OP_PHASE,    C_NEXT,   A_DISPATCH, FLAG_NONE, PH_DISC);
            6'd23: w = cw(OP_EMIT,     C_ALWAYS, A_FINISH,   FLAG_FIN,  PH_IDLE);
            // reset while sending
            6'd24: w = cw(OP_CLR_TMO,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd25: w = cw(OP_REWIND,   C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd26: w = cw(OP_BUMP_RST, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd27: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd28: w = cw(OP_NOP,      C_ALWAYS, A_WINDOW,   FLAG_NONE, PH_IDLE);
            // timeout while sending
            6'd29: w = cw(OP_BUMP_TMO, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd30: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd31: w = cw(OP_NOP,      C_ALWAYS, A_FINISH,   FLAG_NONE, PH_IDLE);
            // ack while disconnecting
            6'd32: w = cw(OP_CHK_ACK1, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd33: w = cw(OP_NOP,      C_NFLAG,  A_FINRES,   FLAG_NONE, PH_IDLE);
            6'd34: w = cw(OP_PHASE,    C_ALWAYS, A_FINISH,   FLAG_NONE, PH_CLOSED);
            6'd35: w = cw(OP_EMIT,     C_ALWAYS, A_FINISH,   FLAG_FIN | FLAG_RES, PH_IDLE);
            // reset while disconnecting
            6'd36: w = cw(OP_CLR_TMO,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd37: w = cw(OP_BUMP_RST, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd38: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd39: w = cw(OP_NOP,      C_ALWAYS, A_FINRES,   FLAG_NONE, PH_IDLE);
            // timeout while disconnecting
            6'd40: w = cw(OP_BUMP_TMO, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd41: w = cw(OP_NOP,      C_FLAG,   A_FAIL,     FLAG_NONE, PH_IDLE);
            6'd42: w = cw(OP_NOP,      C_ALWAYS, A_FINRES,   FLAG_NONE, PH_IDLE);
            6'd43: w = cw(OP_PHASE,    C_ALWAYS, A_FINISH,   FLAG_NONE, PH_IDLE);
            // data window: four steps per packet
            6'd44: w = cw(OP_WIN_INIT, C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd45: w = cw(OP_IDX,      C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd46: w = cw(OP_CHK_IDX,  C_NEXT,   A_DISPATCH, FLAG_NONE, PH_IDLE);
            6'd47: w = cw(OP_NOP,      C_FLAG,   A_FINISH,   FLAG_NONE, PH_IDLE);
            6'd48: w = cw(OP_DAT,      C_MORE,   A_WIN_LOOP, FLAG_NONE, PH_IDLE);
            6'd49: w = cw(OP_FLUSH,    C_ALWAYS, A_DISPATCH, FLAG_NONE, PH_IDLE);
            default: w = cw(OP_NOP,    C_ALWAYS, A_DISPATCH, FLAG_NONE, PH_IDLE);
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_entry(phase_t phase, logic [2:0] req);
        upc_t a;
        a = A_FINISH;
        case (phase)
            PH_IDLE, PH_CLOSED, PH_FAILED:
            begin
                if (req == REQ_START)
                    a = A_START;
            end
            PH_CONN:
            begin
                case (req)
                    REQ_ACK:     a = A_CONN_ACK;
                    REQ_RST:     a = A_CONN_RST;
                    REQ_OTHER:   a = A_SYNRES;
                    REQ_TIMEOUT: a = A_CONN_TMO;
                    default:     a = A_FINISH;
                endcase
            end
            PH_SEND:
            begin
                case (req)
                    REQ_ACK:     a = A_SEND_ACK;
                    REQ_RST:     a = A_SEND_RST;
                    REQ_OTHER:   a = A_WINDOW;
                    REQ_TIMEOUT: a = A_SEND_TMO;
                    default:     a = A_FINISH;
                endcase
            end
            PH_DISC:
            begin
                case (req)
                    REQ_ACK:     a = A_DISC_ACK;
                    REQ_RST:     a = A_DISC_RST;
                    REQ_OTHER:   a = A_FINRES;
                    REQ_TIMEOUT: a = A_DISC_TMO;
                    default:     a = A_FINISH;
                endcase
            end
            default: a = A_BAD_PHASE;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/rdsf_seq.sv =====
module rdsf_seq
    import rdsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_req,
    input  phase_t     phase,
    input  status_t    status,
    output logic       in_ready,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_plus1;

    assign ctrl      = ucode_rom(upc_reg);
    assign in_ready  = (ctrl.cond == C_WAIT);
    assign upc_plus1 = upc_reg + upc_t'(1);

    always_comb
    begin
        upc_next = upc_reg;
        if (ctrl.cond == C_WAIT)
        begin
            if (in_valid)
                upc_next = dispatch_entry(phase, in_req);
        end
        else if (!status.stall)
        begin
            case (ctrl.cond)
                C_NEXT:   upc_next = upc_plus1;
                C_ALWAYS: upc_next = ctrl.target;
                C_FLAG:   upc_next = status.flag ? ctrl.target : upc_plus1;
                C_NFLAG:  upc_next = status.flag ? upc_plus1 : ctrl.target;
                C_MORE:   upc_next = status.more ? ctrl.target : upc_plus1;
                default:  upc_next = A_DISPATCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= A_DISPATCH;
        else
            upc_reg <= upc_next;
    end

endmodule

// ===== rtl/rdsf_datapath.sv =====
module rdsf_datapath
    import rdsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_fire,
    input  logic [31:0]           in_ack,
    input  logic [15:0]           in_win,
    input  ctrl_word_t            ctrl,
    input  logic                  out_free,
    output phase_t                phase,
    output status_t               status,
    output logic                  push_valid,
    output result_t               push_data
);

    logic [30:0] file_length_reg,   file_length_next;
    logic [31:0] init_seq_reg,      init_seq_next;
    logic [7:0]  reset_limit_reg,   reset_limit_next;
    logic [7:0]  timeout_limit_reg, timeout_limit_next;
    logic [11:0] payload_bytes_reg, payload_bytes_next;

    phase_t      phase_reg,         phase_next;
    logic [31:0] seq_now_reg,       seq_now_next;
    logic [31:0] seq_before_reg,    seq_before_next;
    logic [31:0] seq_base_reg,      seq_base_next;
    logic [7:0]  resets_seen_reg,   resets_seen_next;
    logic [7:0]  timeouts_seen_reg, timeouts_seen_next;
    logic [31:0] ack_reg,           ack_next;
    logic [15:0] win_reg,           win_next;
    wcnt_t       wcnt_reg,          wcnt_next;
    logic [31:0] idx_reg,           idx_next;
    logic [30:0] rem_reg,           rem_next;
    logic        res_reg,           res_next;
    logic        flag_reg,          flag_next;
    logic        pend_valid_reg,    pend_valid_next;
    result_t     pend_reg,          pend_next;

    logic [11:0] pay_eff;
    logic [11:0] dat_size;
    logic        need_push;
    logic        stall;
    result_t     empty_res;

    assign pay_eff  = (payload_bytes_reg == 12'd0) ? 12'd1 : payload_bytes_reg;
    assign dat_size = (rem_reg < {19'd0, pay_eff}) ? rem_reg[11:0] : pay_eff;

    assign need_push = ((ctrl.op == OP_EMIT || ctrl.op == OP_DAT) && pend_valid_reg)
                       || (ctrl.op == OP_FLUSH);
    assign stall     = need_push && !out_free;

    assign phase        = phase_reg;
    assign status.flag  = flag_reg;
    assign status.more  = (wcnt_reg > wcnt_t'(1));
    assign status.stall = stall;

    always_comb
    begin
        empty_res       = '0;
        empty_res.phase = phase_reg;
        empty_res.last  = 1'b1;

        push_valid = 1'b0;
        push_data  = pend_reg;
        push_data.phase = phase_reg;
        push_data.last  = 1'b0;
        if (need_push && out_free)
        begin
            push_valid = 1'b1;
            if (ctrl.op == OP_FLUSH)
            begin
                if (pend_valid_reg)
                    push_data.last = 1'b1;
                else
                    push_data = empty_res;
            end
        end
    end

    always_comb
    begin
        file_length_next   = file_length_reg;
        init_seq_next      = init_seq_reg;
        reset_limit_next   = reset_limit_reg;
        timeout_limit_next = timeout_limit_reg;
        payload_bytes_next = payload_bytes_reg;
        phase_next         = phase_reg;
        seq_now_next       = seq_now_reg;
        seq_before_next    = seq_before_reg;
        seq_base_next      = seq_base_reg;
        resets_seen_next   = resets_seen_reg;
        timeouts_seen_next = timeouts_seen_reg;
        ack_next           = ack_reg;
        win_next           = win_reg;
        wcnt_next          = wcnt_reg;
        idx_next           = idx_reg;
        rem_next           = rem_reg;
        res_next           = res_reg;
        flag_next          = flag_reg;
        pend_valid_next    = pend_valid_reg;
        pend_next          = pend_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILE_LENGTH:   file_length_next   = cfg_data[30:0];
                CFG_INIT_SEQ:      init_seq_next      = cfg_data[31:0];
                CFG_RESET_LIMIT:   reset_limit_next   = cfg_data[7:0];
                CFG_TIMEOUT_LIMIT: timeout_limit_next = cfg_data[7:0];
                CFG_PAYLOAD_BYTES: payload_bytes_next = cfg_data[11:0];
                default: ;
            endcase
        end

        if (in_fire)
        begin
            ack_next = in_ack;
            win_next = in_win;
        end

        if (!stall)
        begin
            case (ctrl.op)
                OP_START:
                begin
                    seq_now_next       = init_seq_reg;
                    seq_base_next      = init_seq_reg + 32'd1;
                    seq_before_next    = '0;
                    resets_seen_next   = '0;
                    timeouts_seen_next = '0;
                    phase_next         = PH_CONN;
                end
                OP_EMIT:
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '0;
                    pend_next.valid = 1'b1;
                    pend_next.flags = ctrl.flags;
                    pend_next.seq   = seq_now_reg;
                end
                OP_CLR_TMO:  timeouts_seen_next = '0;
                OP_CHK_ACK1: flag_next = (ack_reg == seq_now_reg + 32'd1);
                OP_INC_SEQ:  seq_now_next = seq_now_reg + 32'd1;
                OP_PHASE:    phase_next = ctrl.phase;
                OP_ACK_SEQ:
                begin
                    seq_before_next = seq_now_reg;
                    seq_now_next    = ack_reg;
                end
                OP_REWIND:   seq_now_next = seq_base_reg;
                OP_BUMP_RST:
                begin
                    flag_next = (resets_seen_reg > reset_limit_reg);
                    if (!(resets_seen_reg > reset_limit_reg) && resets_seen_reg != 8'hFF)
                        resets_seen_next = resets_seen_reg + 8'd1;
                end
                OP_BUMP_TMO:
                begin
                    flag_next = (timeouts_seen_reg > timeout_limit_reg);
                    if (!(timeouts_seen_reg > timeout_limit_reg) && timeouts_seen_reg != 8'hFF)
                        timeouts_seen_next = timeouts_seen_reg + 8'd1;
                end
                OP_IDX:      idx_next = seq_now_reg - seq_base_reg;
                OP_CHK_IDX:
                begin
                    // flag marks no data left at this position
                    flag_next = (idx_reg >= {1'b0, file_length_reg});
                    rem_next  = file_length_reg - idx_reg[30:0];
                    res_next  = (seq_now_reg < seq_before_reg);
                end
                OP_WIN_INIT:
                begin
                    if (win_reg == 16'd0)
                        wcnt_next = wcnt_t'(1);
                    else if (win_reg > 16'(MAX_WINDOW))
                        wcnt_next = wcnt_t'(MAX_WINDOW);
                    else
                        wcnt_next = win_reg[WCNT_W-1:0];
                end
                OP_DAT:
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '0;
                    pend_next.valid = 1'b1;
                    pend_next.flags = FLAG_DAT | (res_reg ? FLAG_RES : FLAG_NONE);
                    pend_next.seq   = seq_now_reg;
                    pend_next.len   = dat_size;
                    pend_next.off   = idx_reg[30:0];
                    seq_now_next    = seq_now_reg + {20'd0, dat_size};
                    wcnt_next       = wcnt_reg - wcnt_t'(1);
                end
                OP_FLUSH:    pend_valid_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg   <= '0;
            init_seq_reg      <= '0;
            reset_limit_reg   <= 8'd10;
            timeout_limit_reg <= 8'd10;
            payload_bytes_reg <= 12'd1024;
            phase_reg         <= PH_IDLE;
            seq_now_reg       <= '0;
            seq_before_reg    <= '0;
            seq_base_reg      <= '0;
            resets_seen_reg   <= '0;
            timeouts_seen_reg <= '0;
            wcnt_reg          <= '0;
            flag_reg          <= 1'b0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            file_length_reg   <= file_length_next;
            init_seq_reg      <= init_seq_next;
            reset_limit_reg   <= reset_limit_next;
            timeout_limit_reg <= timeout_limit_next;
            payload_bytes_reg <= payload_bytes_next;
            phase_reg         <= phase_next;
            seq_now_reg       <= seq_now_next;
            seq_before_reg    <= seq_before_next;
            seq_base_reg      <= seq_base_next;
            resets_seen_reg   <= resets_seen_next;
            timeouts_seen_reg <= timeouts_seen_next;
            wcnt_reg          <= wcnt_next;
            flag_reg          <= flag_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg  <= ack_next;
        win_reg  <= win_next;
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

endmodule

// ===== rtl/rdsf_out_reg.sv =====
module rdsf_out_reg
    import rdsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  result_t push_data,
    input  logic    m_ready,
    output logic    out_free,
    output logic    m_valid,
    output result_t m_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/reliable_datagram_sender_fsm.sv =====
// Sender control for a windowed go-back-N datagram transfer.
// Slave stream: one network event per transaction (start, ACK, RST, other,
// timeout). Master stream: one packet descriptor per transaction, at least one
// per event; tlast marks the final descriptor of an event, and an event that
// sends nothing yields one descriptor with tuser bit 0 low.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// no event is in progress: a rule for the user that the block does not enforce.
// Timing: an event is taken in the dispatch step, then its microcode routine
// runs from a constant control store. A data window runs a four-step loop per
// packet (offset, remaining bytes, end check, clipped emit). A descriptor
// enters the output register at the next emit step or at the final step of
// its routine and is presented in the following cycle; the next event can be
// taken in the cycle after the final descriptor enters the output register.
// A stalled receiver freezes the sequencer at its next emit or final step; one
// descriptor waits in the output register and one more in a staging register.
// Reset returns to idle with sequence state cleared and the registers at
// their defaults.
`include "assert_macros.svh"

module reliable_datagram_sender_fsm
    import rdsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // ack_number, adv_window
    input  logic [2:0]            s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // packet_sequence, payload_length, file_offset, phase, zero pad
    output logic [79:0]           m_axis_tdata,
    output logic [4:0]            m_axis_tuser,  // packet_valid, packet_flags
    output logic                  m_axis_tlast
);

    ctrl_word_t ctrl;
    status_t    status;
    phase_t     phase;
    logic       in_fire;
    logic       out_free;
    logic       push_valid;
    result_t    push_data;
    result_t    out_data;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rdsf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_req   (s_axis_tuser),
        .phase    (phase),
        .status   (status),
        .in_ready (s_axis_tready),
        .ctrl     (ctrl)
    );

    rdsf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .in_ack     (s_axis_tdata[31:0]),
        .in_win     (s_axis_tdata[47:32]),
        .ctrl       (ctrl),
        .out_free   (out_free),
        .phase      (phase),
        .status     (status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    rdsf_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .m_ready    (m_axis_tready),
        .out_free   (out_free),
        .m_valid    (m_axis_tvalid),
        .m_data     (out_data)
    );

    assign m_axis_tdata = {2'b00, out_data.phase, out_data.off, out_data.len, out_data.seq};
    assign m_axis_tuser = {out_data.flags, out_data.valid};
    assign m_axis_tlast = out_data.last;

    `RDSF_ASSERT(a_push_only_when_free, clk, rst_n, !push_valid || !m_axis_tvalid || m_axis_tready)
    `RDSF_ASSERT_NEXT(a_leave_dispatch, clk, rst_n, in_fire, !s_axis_tready)
    `RDSF_ASSERT(a_last_from_flush, clk, rst_n, !(push_valid && push_data.last) || ctrl.op == OP_FLUSH)

endmodule

// ===== test/datagram_sender_checker.sv =====
`timescale 1ns / 1ps

module datagram_sender_checker
    import rdsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // ack_number, adv_window
    input  logic [2:0]            s_axis_tuser,  // req_type
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // packet_sequence, payload_length, file_offset, phase, zero pad
    input  logic [79:0]           m_axis_tdata,
    input  logic [4:0]            m_axis_tuser,  // packet_valid, packet_flags
    input  logic                  m_axis_tlast,
    output int                    mismatches,
    output int                    outstanding,
    output int                    descriptors
);

    logic [30:0] file_len;
    logic [31:0] init_seq;
    logic [7:0]  rst_limit;
    logic [7:0]  tmo_limit;
    logic [11:0] max_payload;

    phase_t      phase_q;
    logic [31:0] seq_now;
    logic [31:0] seq_prev;
    logic [31:0] seq_base;
    logic [7:0]  rst_count;
    logic [7:0]  tmo_count;

    result_t     packets_due[$];
    result_t     burst[$];
    result_t     head;

    function automatic logic [7:0] count_up(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    task automatic add_packet(input logic [3:0] flags, input logic [31:0] seq,
                              input logic [11:0] len, input logic [30:0] off);
        result_t r;
        r.valid = 1'b1;
        r.flags = flags;
        r.seq   = seq;
        r.len   = len;
        r.off   = off;
        r.phase = PH_IDLE;
        r.last  = 1'b0;
        burst.push_back(r);
    endtask

    // Release up to one window of DAT packets, clipped to the bytes left.
    task automatic emit_window(input logic [15:0] win_in);
        int unsigned win;
        int unsigned n;
        logic [31:0] pay;
        logic [31:0] idx;
        logic [31:0] rem;
        logic [31:0] size;
        win = (win_in == 16'd0) ? 32'd1 : {16'd0, win_in};
        if (win > MAX_WINDOW)
            win = MAX_WINDOW;
        pay = (max_payload == 12'd0) ? 32'd1 : {20'd0, max_payload};
        n = 0;
        while (n < win && (seq_now - seq_base) < {1'b0, file_len})
        begin
            idx  = seq_now - seq_base;
            rem  = {1'b0, file_len} - idx;
            size = (rem < pay) ? rem : pay;
            add_packet(FLAG_DAT | ((seq_now < seq_prev) ? FLAG_RES : FLAG_NONE),
                       seq_now, size[11:0], idx[30:0]);
            seq_now = seq_now + size;
            n++;
        end
    endtask

    task automatic sender_event(input logic [2:0] req, input logic [31:0] ack,
                                input logic [15:0] win);
        result_t r;
        burst.delete();
        case (phase_q)
            PH_IDLE, PH_CLOSED, PH_FAILED:
            begin
                if (req == REQ_START)
                begin
                    seq_now   = init_seq;
                    seq_base  = init_seq + 32'd1;
                    seq_prev  = 32'd0;
                    rst_count = 8'd0;
                    tmo_count = 8'd0;
                    phase_q   = PH_CONN;
                    add_packet(FLAG_SYN, seq_now, 12'd0, 31'd0);
                end
            end
            PH_CONN:
            begin
                case (req)
                    REQ_ACK:
                    begin
                        tmo_count = 8'd0;
                        if (ack == seq_now + 32'd1)
                        begin
                            seq_now = seq_now + 32'd1;
                            phase_q = PH_SEND;
                            emit_window(win);
                        end
                        else
                            add_packet(FLAG_SYN | FLAG_RES, seq_now, 12'd0, 31'd0);
                    end
                    REQ_RST:
                    begin
                        tmo_count = 8'd0;
                        if (rst_count > rst_limit)
                            phase_q = PH_FAILED;
                        else
                        begin
                            rst_count = count_up(rst_count);
                            add_packet(FLAG_SYN | FLAG_RES, seq_now, 12'd0, 31'd0);
                        end
                    end
                    REQ_OTHER:
                        add_packet(FLAG_SYN | FLAG_RES, seq_now, 12'd0, 31'd0);
                    REQ_TIMEOUT:
                    begin
                        if (tmo_count > tmo_limit)
                            phase_q = PH_FAILED;
                        else
                        begin
                            tmo_count = count_up(tmo_count);
                            add_packet(FLAG_SYN | FLAG_RES, seq_now, 12'd0, 31'd0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_SEND:
            begin
                case (req)
                    REQ_ACK:
                    begin
                        tmo_count = 8'd0;
                        seq_prev  = seq_now;
                        seq_now   = ack;
                        if ((seq_now - seq_base) >= {1'b0, file_len})
                        begin
                            phase_q = PH_DISC;
                            add_packet(FLAG_FIN, seq_now, 12'd0, 31'd0);
                        end
                        else
                            emit_window(win);
                    end
                    REQ_RST:
                    begin
                        // go back to the first data byte
                        tmo_count = 8'd0;
                        seq_now   = seq_base;
                        if (rst_count > rst_limit)
                            phase_q = PH_FAILED;
                        else
                        begin
                            rst_count = count_up(rst_count);
                            emit_window(win);
                        end
                    end
                    REQ_OTHER:
                        emit_window(win);
                    REQ_TIMEOUT:
                    begin
                        if (tmo_count > tmo_limit)
                            phase_q = PH_FAILED;
                        else
                            tmo_count = count_up(tmo_count);
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_DISC:
            begin
                case (req)
                    REQ_ACK:
                    begin
                        if (ack == seq_now + 32'd1)
                            phase_q = PH_CLOSED;
                        else
                            add_packet(FLAG_FIN | FLAG_RES, seq_now, 12'd0, 31'd0);
                    end
                    REQ_RST:
                    begin
                        tmo_count = 8'd0;
                        if (rst_count > rst_limit)
                            phase_q = PH_FAILED;
                        else
                        begin
                            rst_count = count_up(rst_count);
                            add_packet(FLAG_FIN | FLAG_RES, seq_now, 12'd0, 31'd0);
                        end
                    end
                    REQ_OTHER:
                        add_packet(FLAG_FIN | FLAG_RES, seq_now, 12'd0, 31'd0);
                    REQ_TIMEOUT:
                    begin
                        if (tmo_count > tmo_limit)
                            phase_q = PH_FAILED;
                        else
                        begin
                            tmo_count = count_up(tmo_count);
                            add_packet(FLAG_FIN | FLAG_RES, seq_now, 12'd0, 31'd0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
                phase_q = PH_IDLE;
        endcase

        // an event that sends nothing still yields one empty descriptor
        if (burst.size() == 0)
        begin
            r = '0;
            burst.push_back(r);
        end
        foreach (burst[k])
        begin
            r       = burst[k];
            r.phase = phase_q;
            r.last  = (k == burst.size() - 1);
            packets_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_len    = 31'd0;
            init_seq    = 32'd0;
            rst_limit   = 8'd10;
            tmo_limit   = 8'd10;
            max_payload = 12'd1024;
            phase_q     = PH_IDLE;
            seq_now     = 32'd0;
            seq_prev    = 32'd0;
            seq_base    = 32'd0;
            rst_count   = 8'd0;
            tmo_count   = 8'd0;
            packets_due.delete();
            mismatches  = 0;
            descriptors = 0;
        end
        else
        begin
            // a descriptor leaving now always belongs to an earlier event
            if (m_axis_tvalid && m_axis_tready)
            begin
                descriptors++;
                if (packets_due.size() == 0)
                begin
                    $error("descriptor with no event pending: tuser 0x%0h tdata 0x%0h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    head = packets_due.pop_front();
                    check_field("packet_valid", 32'(head.valid), 32'(m_axis_tuser[0]));
                    check_field("packet_flags", 32'(head.flags), 32'(m_axis_tuser[4:1]));
                    check_field("packet_sequence", head.seq, m_axis_tdata[31:0]);
                    check_field("payload_length", 32'(head.len), 32'(m_axis_tdata[43:32]));
                    check_field("file_offset", 32'(head.off), 32'(m_axis_tdata[74:44]));
                    check_field("phase", 32'(head.phase), 32'(m_axis_tdata[77:75]));
                    check_field("last_of_run", 32'(head.last), 32'(m_axis_tlast));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILE_LENGTH:   file_len    = cfg_data[30:0];
                    CFG_INIT_SEQ:      init_seq    = cfg_data[31:0];
                    CFG_RESET_LIMIT:   rst_limit   = cfg_data[7:0];
                    CFG_TIMEOUT_LIMIT: tmo_limit   = cfg_data[7:0];
                    CFG_PAYLOAD_BYTES: max_payload = cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                sender_event(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
        end
        outstanding = packets_due.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rdsf_pkg::*;

    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
    localparam int         EVENTS_PER_SETTING = 28;
    localparam int         NUM_SETTINGS       = 5;
    localparam longint     RUN_LIMIT_NS       = 64'd10_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;  // ack_number, adv_window
    logic [2:0]            s_axis_tuser;  // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // packet_sequence, payload_length, file_offset, phase, zero pad
    logic [79:0]           m_axis_tdata;
    logic [4:0]            m_axis_tuser;  // packet_valid, packet_flags
    logic                  m_axis_tlast;

    int                    mismatches;
    int                    outstanding;
    int                    descriptors;

    // copy of what was last written, used to shape well-formed transfers
    logic [30:0]           file_cfg;
    logic [31:0]           init_cfg;
    logic [11:0]           pay_cfg;

    int unsigned           src_idle_pct;
    int unsigned           sink_stall_pct;
    int unsigned           events_sent;
    int unsigned           transfers;
    int unsigned           settings;

    reliable_datagram_sender_fsm i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    datagram_sender_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .descriptors   (descriptors)
    );

    always #5 clk = ~clk;

    // receiver: stall in random bursts
    always
    begin
        @(negedge clk);
        if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
        begin
            m_axis_tready = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        m_axis_tready = 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[reliable_datagram_sender_fsm] ERROR");
        $finish;
    end

    task automatic send_event(input logic [2:0] req, input logic [31:0] ack,
                              input logic [15:0] win);
        int unsigned gap;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
            gap = $urandom_range(1, 19);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {win, ack};
        s_axis_tuser  = req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        events_sent++;
    endtask

    // hold the sender until every descriptor has been taken
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(input logic [30:0] file_len, input logic [31:0] init_seq,
                                 input logic [7:0] rst_lim, input logic [7:0] tmo_lim,
                                 input logic [11:0] pay);
        cfg_write(CFG_FILE_LENGTH, {1'b0, file_len});
        cfg_write(CFG_INIT_SEQ, init_seq);
        cfg_write(CFG_RESET_LIMIT, {24'd0, rst_lim});
        cfg_write(CFG_TIMEOUT_LIMIT, {24'd0, tmo_lim});
        cfg_write(CFG_PAYLOAD_BYTES, {20'd0, pay});
        file_cfg = file_len;
        init_cfg = init_seq;
        pay_cfg  = pay;
        settings++;
    endtask

    function automatic logic [15:0] rand_win();
        logic [15:0] w;
        case ($urandom_range(0, 7))
            0:       w = 16'($urandom_range(0, 65535));
            1:       w = 16'($urandom_range(MAX_WINDOW - 2, MAX_WINDOW + 8));
            default: w = 16'($urandom_range(0, 6));
        endcase
        return w;
    endfunction

    task automatic maybe_noise();
        logic [2:0] odd_req;
        if ($urandom_range(0, 99) < 15)
        begin
            odd_req = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
            case ($urandom_range(0, 5))
                0:       send_event(REQ_RST, $urandom, rand_win());
                1:       send_event(REQ_OTHER, $urandom, rand_win());
                2:       send_event(REQ_TIMEOUT, $urandom, rand_win());
                3:       send_event(REQ_ACK, $urandom, rand_win());
                4:       send_event(odd_req, $urandom, rand_win());
                default: send_event(REQ_START, $urandom, rand_win());
            endcase
        end
    endtask

    // connect, acknowledge data in random steps (sometimes backwards), then close
    task automatic run_transfer();
        logic [31:0] first;
        logic [31:0] len;
        logic [31:0] pay_eff;
        logic [31:0] k;
        int unsigned acks;
        first   = init_cfg + 32'd1;
        len     = {1'b0, file_cfg};
        pay_eff = (pay_cfg == 12'd0) ? 32'd1 : {20'd0, pay_cfg};
        k       = 32'd0;
        acks    = $urandom_range(0, 4);
        maybe_noise();
        send_event(REQ_START, $urandom, rand_win());
        maybe_noise();
        send_event(REQ_ACK, first, rand_win());
        if (len != 0)
        begin
            repeat (acks)
            begin
                maybe_noise();
                case ($urandom_range(0, 5))
                    0:       k = $urandom_range(0, k);
                    1:       k = $urandom_range(0, len - 1);
                    default: k = k + $urandom_range(1, 8) * pay_eff;
                endcase
                if (k >= len)
                    k = len - 1;
                send_event(REQ_ACK, first + k, rand_win());
            end
        end
        maybe_noise();
        send_event(REQ_ACK, first + len, rand_win());
        maybe_noise();
        send_event(REQ_ACK, first + len + 32'd1, rand_win());
        transfers++;
    endtask

    initial
    begin
        int unsigned mark;
        int          s;
        logic [31:0] base;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FILE_LENGTH;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = REQ_START;
        file_cfg       = 31'd0;
        init_cfg       = 32'd0;
        pay_cfg        = 12'd1024;
        src_idle_pct   = 20;
        sink_stall_pct = 10;
        events_sent    = 0;
        transfers      = 0;
        settings       = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: empty file, sequence zero
        send_event(REQ_ACK, 32'd0, 16'd0);
        send_event(REQ_START, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(REQ_START, 32'd0, 16'd0);
        send_event(REQ_RESERVED_LAST, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(REQ_OTHER, 32'd0, 16'd1);
        send_event(REQ_ACK, 32'd2, 16'd1);
        send_event(REQ_TIMEOUT, 32'd0, 16'd0);
        send_event(REQ_RST, 32'd0, 16'd0);
        send_event(REQ_ACK, 32'd1, 16'd0);
        send_event(REQ_OTHER, 32'd0, 16'd3);
        send_event(REQ_TIMEOUT, 32'd0, 16'd0);
        send_event(REQ_ACK, 32'd1, 16'd5);
        send_event(REQ_OTHER, 32'd0, 16'd0);
        send_event(REQ_TIMEOUT, 32'd0, 16'd0);
        send_event(REQ_RST, 32'd0, 16'd0);
        send_event(REQ_ACK, 32'd7, 16'd0);
        send_event(REQ_ACK, 32'd2, 16'd0);
        drain();

        // largest file and payload, sequence wrapping past zero, zero limits
        apply_setting(31'h7FFF_FFFF, 32'hFFFF_FFF0, 8'd0, 8'd0, 12'd4095);
        base = 32'hFFFF_FFF1;
        send_event(REQ_START, 32'd0, 16'd0);
        send_event(REQ_ACK, base, 16'hFFFF);
        send_event(REQ_ACK, base + 32'h7FFF_FFFF - 32'd100, 16'd3);
        send_event(REQ_ACK, base + 32'd3 * 32'd4095, 16'd2);
        send_event(REQ_TIMEOUT, 32'd0, 16'd0);
        send_event(REQ_TIMEOUT, 32'd0, 16'd0);
        send_event(REQ_START, 32'd0, 16'd0);
        send_event(REQ_RST, 32'd0, 16'd0);
        send_event(REQ_RST, 32'd0, 16'd0);
        drain();

        for (s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s == NUM_SETTINGS - 1)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       src_idle_pct = 0;
                    1:       src_idle_pct = 15;
                    default: src_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       sink_stall_pct = 0;
                    1:       sink_stall_pct = 5;
                    default: sink_stall_pct = 20;
                endcase
            end
            case (s)
                0: apply_setting(31'($urandom_range(1, 60)),
                                 32'hFFFF_FFFF - $urandom_range(0, 40),
                                 8'd0, 8'd0, 12'd1);
                1: apply_setting(31'($urandom_range(0, 3000)), $urandom,
                                 8'd255, 8'd255, 12'd0);
                2: apply_setting(31'($urandom_range(0, 20000)), $urandom,
                                 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                 12'd4095);
                3: apply_setting(31'($urandom), $urandom, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 12'($urandom_range(1, 4095)));
                default: apply_setting(31'($urandom_range(0, 50000)), $urandom,
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       12'($urandom_range(0, 4095)));
            endcase
            mark = events_sent;
            run_transfer();
            drain();
            while (events_sent - mark < EVENTS_PER_SETTING)
                run_transfer();
            drain();
        end

        repeat (20) @(negedge clk);
        $display("Run covered %0d network events and %0d packet descriptors over %0d settings,",
                 events_sent, descriptors, settings + 1);
        $display("with %0d scripted transfers mixed with resets, timeouts, bad and stray packets.",
                 transfers);
        if (mismatches == 0 && outstanding == 0)
            $display("[reliable_datagram_sender_fsm] OK");
        else
            $display("[reliable_datagram_sender_fsm] ERROR");
        $finish;
    end

endmodule
